FILE: src/wch_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wch_pkg
// shared types and constants of the weighted colour histogram
// ---------------------------------------------------------------------------
package wch_pkg;

   localparam int MAX_BINS   = 64;
   localparam int COMPONENTS = 4;
   localparam int ROWS       = COMPONENTS + 1;
   localparam int ENTRIES    = ROWS * MAX_BINS;
   localparam int ADDR_W     = $clog2(ENTRIES);
   localparam int BIN_W      = $clog2(MAX_BINS);
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BRIGHT_LIMIT = 2'd0,
      CSR_FAINT_LIMIT  = 2'd1,
      CSR_BIN_WIDTH    = 2'd2,
      CSR_LAST_BIN     = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_ACCUMULATE = 1'b0,
      MODE_READ       = 1'b1
   } mode_type;

   typedef struct packed {
      logic               mode;
      logic [2:0]         component;
      logic signed [15:0] apparent_mag;
      logic [31:0]        main_weight;
      logic [31:0]        giant_weight;
      logic signed [15:0] main_colour;
      logic signed [15:0] giant_colour;
      logic [5:0]         read_bin;
   } req_type;

   typedef struct packed {
      logic               in_window;
      logic [5:0]         main_bin;
      logic [5:0]         giant_bin;
      logic [47:0]        bin_count;
      logic [47:0]        row_weight_total;
      logic signed [63:0] row_colour_sum;
      logic [47:0]        row_giant_total;
   } rsp_type;

endpackage

FILE: src/weighted_colour_histogram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weighted_colour_histogram
// per-component weighted colour histograms with row sums and a totals row
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A read transaction
// passes through a memory-read state and a response state before its result is
// shown; an accumulate transaction runs the 15-step restoring divider for the two
// colour bins, the multiply states MUL1 and MUL2, a product-sum state, four
// read-modify-write passes (a read and a write state each) on the single-port
// histogram memory, a row-sum state and a result state. An accumulate to the
// totals row or beyond skips the memory and row-sum passes. busy may fall in the
// same cycle rsp_valid is shown, so the next transaction can overlap the result cycle.
// The result is shown for one cycle only and cannot be stalled. After reset
// the memory is cleared one entry per cycle, all 320 entries, with busy held high;
// csr writes are taken at any time but should only be made while idle.
module weighted_colour_histogram (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  wch_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output wch_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [wch_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [wch_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int DIV_STEPS   = 15;
   localparam int CNT_W       = $clog2(DIV_STEPS);
   localparam int BIN_W_LOCAL = wch_pkg::BIN_W;

   typedef enum logic [11:0] {
      S_CLEAR  = 12'b0000_0000_0001,
      S_IDLE   = 12'b0000_0000_0010,
      S_RREAD  = 12'b0000_0000_0100,
      S_RRESP  = 12'b0000_0000_1000,
      S_DIV    = 12'b0000_0001_0000,
      S_MUL1   = 12'b0000_0010_0000,
      S_MUL2   = 12'b0000_0100_0000,
      S_PSUM   = 12'b0000_1000_0000,
      S_RMW_RD = 12'b0001_0000_0000,
      S_RMW_WR = 12'b0010_0000_0000,
      S_SUMS   = 12'b0100_0000_0000,
      S_RESP   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic signed [15:0] bright_ff, faint_ff;
   logic [14:0]        bin_width_ff;
   logic [5:0]         last_bin_ff;

   // latched transaction
   wch_pkg::req_type   req_ff;
   logic               inwin_ff;
   logic [31:0]        wm_ff, wg_ff;

   // histogram memory
   logic [47:0]               hist_mem [wch_pkg::ENTRIES];
   logic [47:0]               rd_data_ff;
   logic [wch_pkg::ADDR_W-1:0] mem_addr;
   logic                      mem_we;
   logic [47:0]               mem_wdata;
   logic [wch_pkg::ADDR_W-1:0] clr_cnt_ff;

   // row sums, small enough for flops
   logic signed [63:0] colour_sum_ff   [wch_pkg::ROWS];
   logic [47:0]        weight_total_ff [wch_pkg::ROWS];
   logic [47:0]        giant_total_ff  [wch_pkg::ROWS];

   // dividers: index 0 main, 1 giant
   logic [14:0] num_ff [2];
   logic [15:0] rem_ff [2];
   logic [14:0] quo_ff [2];
   logic [14:0] num_in [2];
   logic [15:0] rem_in [2];
   logic [14:0] quo_in [2];
   logic [CNT_W-1:0] div_cnt_ff;
   logic [14:0] divisor;
   logic [BIN_W_LOCAL-1:0] bin_q [2];
   logic [BIN_W_LOCAL-1:0] bm_ff, bg_ff, top_bin;

   // products
   logic signed [48:0] prod_a_ff, prod_b_ff;
   logic signed [49:0] prod_ff;

   logic [1:0] step_ff;
   logic       accept, comp_ok, read_ok;

   wch_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   function automatic logic [47:0] add48(input logic [47:0] a, input logic [33:0] b);
      logic [48:0] s;
      s = {1'b0, a} + 49'(b);
      return s[48] ? wch_pkg::MAX48 : s[47:0];
   endfunction

   function automatic logic signed [63:0] add_s64(input logic signed [63:0] a,
                                                  input logic signed [49:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63])
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign accept    = start && (state_ff == S_IDLE);
   assign comp_ok   = (req_ff.component < 3'(wch_pkg::COMPONENTS));
   assign read_ok   = (req_ff.component < 3'(wch_pkg::ROWS));

   // zero width acts as one, last bin capped to store
   assign divisor = (bin_width_ff == 15'd0) ? 15'd1 : bin_width_ff;
   assign top_bin = (32'(last_bin_ff) > wch_pkg::MAX_BINS - 1) ?
                    BIN_W_LOCAL'(wch_pkg::MAX_BINS - 1) : BIN_W_LOCAL'(last_bin_ff);

   // one restoring step per cycle on both dividers
   always_comb begin
      logic [15:0] trial;
      for (int k = 0; k < 2; k++) begin
         trial     = {rem_ff[k][14:0], num_ff[k][14]};
         num_in[k] = {num_ff[k][13:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in[k] = trial - {1'b0, divisor};
            quo_in[k] = {quo_ff[k][13:0], 1'b1};
         end else begin
            rem_in[k] = trial;
            quo_in[k] = {quo_ff[k][13:0], 1'b0};
         end
         bin_q[k] = (quo_ff[k] > 15'(top_bin)) ? top_bin : BIN_W_LOCAL'(quo_ff[k]);
      end
   end

   // histogram address: step bit 1 picks the totals row, bit 0 the giant bin
   always_comb begin
      logic [wch_pkg::ADDR_W-1:0] row;
      logic [wch_pkg::ADDR_W-1:0] bin;
      logic [31:0]                w;
      row = step_ff[1] ? wch_pkg::ADDR_W'(wch_pkg::COMPONENTS)
                       : wch_pkg::ADDR_W'(req_ff.component);
      bin = step_ff[0] ? wch_pkg::ADDR_W'(bg_ff) : wch_pkg::ADDR_W'(bm_ff);
      w   = step_ff[0] ? wg_ff : wm_ff;
      mem_we    = 1'b0;
      mem_wdata = 48'd0;
      mem_addr  = wch_pkg::ADDR_W'(row * wch_pkg::ADDR_W'(wch_pkg::MAX_BINS) + bin);
      if (state_ff == S_CLEAR) begin
         mem_we   = 1'b1;
         mem_addr = clr_cnt_ff;
      end else if (state_ff == S_RREAD) begin
         mem_addr = wch_pkg::ADDR_W'(wch_pkg::ADDR_W'(req_ff.component)
                    * wch_pkg::ADDR_W'(wch_pkg::MAX_BINS)
                    + wch_pkg::ADDR_W'(req_ff.read_bin));
      end else if (state_ff == S_RMW_WR) begin
         mem_we    = 1'b1;
         mem_wdata = add48(rd_data_ff, {2'b00, w});
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) hist_mem[mem_addr] <= mem_wdata;
      rd_data_ff <= hist_mem[mem_addr];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (32'(clr_cnt_ff) == wch_pkg::ENTRIES - 1) state_in = S_IDLE;
         S_IDLE:   if (start) state_in = (req_data.mode == wch_pkg::MODE_READ) ? S_RREAD
                                                                                : S_DIV;
         S_RREAD:  state_in = S_RRESP;
         S_RRESP:  state_in = S_IDLE;
         S_DIV:    if (32'(div_cnt_ff) == DIV_STEPS - 1) state_in = S_MUL1;
         S_MUL1:   state_in = S_MUL2;
         S_MUL2:   state_in = S_PSUM;
         S_PSUM:   state_in = comp_ok ? S_RMW_RD : S_RESP;
         S_RMW_RD: state_in = S_RMW_WR;
         S_RMW_WR: state_in = (step_ff == 2'd3) ? S_SUMS : S_RMW_RD;
         S_SUMS:   state_in = S_RESP;
         S_RESP:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // result
   always_comb begin
      logic [2:0] c;
      c            = req_ff.component;
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      if (state_ff == S_RRESP) begin
         rsp_valid_in = 1'b1;
         if (read_ok) begin
            if (32'(req_ff.read_bin) < wch_pkg::MAX_BINS) rsp_in.bin_count = rd_data_ff;
            rsp_in.row_weight_total = weight_total_ff[c];
            rsp_in.row_colour_sum   = colour_sum_ff[c];
            rsp_in.row_giant_total  = giant_total_ff[c];
         end
      end else if (state_ff == S_RESP) begin
         rsp_valid_in     = 1'b1;
         rsp_in.in_window = inwin_ff;
         rsp_in.main_bin  = 6'(bm_ff);
         rsp_in.giant_bin = 6'(bg_ff);
         if (comp_ok) begin
            rsp_in.row_weight_total = weight_total_ff[c];
            rsp_in.row_colour_sum   = colour_sum_ff[c];
            rsp_in.row_giant_total  = giant_total_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         bright_ff    <= -16'sd32768;
         faint_ff     <= 16'sd32767;
         bin_width_ff <= 15'd1024;
         last_bin_ff  <= 6'd63;
         div_cnt_ff   <= '0;
         step_ff      <= '0;
         for (int r = 0; r < wch_pkg::ROWS; r++) begin
            colour_sum_ff[r]   <= '0;
            weight_total_ff[r] <= '0;
            giant_total_ff[r]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;

         if (csr_we) begin
            unique case (csr_addr)
               wch_pkg::CSR_BRIGHT_LIMIT: bright_ff    <= csr_wdata;
               wch_pkg::CSR_FAINT_LIMIT:  faint_ff     <= csr_wdata;
               wch_pkg::CSR_BIN_WIDTH:    bin_width_ff <= csr_wdata[14:0];
               wch_pkg::CSR_LAST_BIN:     last_bin_ff  <= csr_wdata[5:0];
               default: ;
            endcase
         end

         if (accept) div_cnt_ff <= '0;
         else if (state_ff == S_DIV) div_cnt_ff <= div_cnt_ff + 1'b1;

         if (state_ff == S_PSUM) step_ff <= '0;
         else if (state_ff == S_RMW_WR) step_ff <= step_ff + 1'b1;

         // both rows updated together, totals row is always distinct
         if (state_ff == S_SUMS) begin
            for (int r = 0; r < wch_pkg::ROWS; r++) begin
               if (r == 32'(req_ff.component) || r == wch_pkg::COMPONENTS) begin
                  colour_sum_ff[r]   <= add_s64(colour_sum_ff[r], prod_ff);
                  weight_total_ff[r] <= add48(weight_total_ff[r],
                                              {2'b00, wm_ff} + {2'b00, wg_ff});
                  giant_total_ff[r]  <= add48(giant_total_ff[r], {2'b00, wg_ff});
               end
            end
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         logic win;
         win      = (req_data.apparent_mag >= bright_ff) &&
                    (req_data.apparent_mag <= faint_ff);
         req_ff   <= req_data;
         inwin_ff <= win;
         wm_ff    <= win ? req_data.main_weight  : 32'd0;
         wg_ff    <= win ? req_data.giant_weight : 32'd0;
         // non-positive colours fall in bin zero
         num_ff[0] <= (req_data.main_colour  > 16'sd0) ? req_data.main_colour[14:0]
                                                       : 15'd0;
         num_ff[1] <= (req_data.giant_colour > 16'sd0) ? req_data.giant_colour[14:0]
                                                       : 15'd0;
         rem_ff[0] <= '0;
         rem_ff[1] <= '0;
         quo_ff[0] <= '0;
         quo_ff[1] <= '0;
      end else if (state_ff == S_DIV) begin
         for (int k = 0; k < 2; k++) begin
            num_ff[k] <= num_in[k];
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
      if (state_ff == S_MUL1) begin
         bm_ff     <= bin_q[0];
         bg_ff     <= bin_q[1];
         prod_a_ff <= $signed({1'b0, wm_ff}) * req_ff.main_colour;
      end
      if (state_ff == S_MUL2)
         prod_b_ff <= $signed({1'b0, wg_ff}) * req_ff.giant_colour;
      if (state_ff == S_PSUM)
         prod_ff <= 50'(prod_a_ff) + 50'(prod_b_ff);
      rsp_ff <= rsp_in;
   end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for weighted_colour_histogram. It runs a table of
// directed transactions and then random ones under a series of csr settings.
// Every result is checked field by field, against the table's expected value
// for typed rows and else against a bit-accurate histogram model kept in the bench.
// ---------------------------------------------------------------------------
module tb;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   wch_pkg::req_type              req_data;
   logic                          rsp_valid;
   wch_pkg::rsp_type              rsp_data;
   logic                          csr_we;
   logic [wch_pkg::CSR_IDX_W-1:0] csr_addr;
   logic [wch_pkg::CSR_W-1:0]     csr_wdata;

   weighted_colour_histogram u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata)
   );

   // model copy of the csr file
   logic signed [15:0] bright_lim;
   logic signed [15:0] faint_lim;
   logic [14:0]        bin_wid;
   logic [5:0]         top_bin;

   // model copy of the stores
   logic [47:0]        hist_store [wch_pkg::ENTRIES];
   logic signed [63:0] colour_acc [wch_pkg::ROWS];
   logic [47:0]        weight_acc [wch_pkg::ROWS];
   logic [47:0]        giant_acc  [wch_pkg::ROWS];

   wch_pkg::rsp_type pending_rsp [$];
   int               mismatches;
   bit               idle_on;

   // directed stimulus table
   typedef struct {
      wch_pkg::req_type r;
      bit               typed;
      wch_pkg::rsp_type e;
   } row_type;
   row_type directed [$];

   always #1 clock = ~clock;

   // ------------------------------------------------------------------ model
   function automatic logic [47:0] sat_add48(logic [47:0] a, logic [33:0] b);
      logic [49:0] s;
      s = a + b;
      return (s > wch_pkg::MAX48) ? wch_pkg::MAX48 : s[47:0];
   endfunction

   function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                    logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63])
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   // truncating divide, negative colours land in bin 0, clamp at top bin
   function automatic logic [5:0] colour_bin(logic signed [15:0] c);
      int unsigned w;
      int unsigned idx;
      if (c <= 0) return '0;
      w   = (bin_wid == 0) ? 1 : bin_wid;
      idx = int'(c) / w;
      return (idx > top_bin) ? top_bin : idx[5:0];
   endfunction

   function automatic wch_pkg::rsp_type histogram_step(wch_pkg::req_type r);
      wch_pkg::rsp_type   o;
      logic [31:0]        wm;
      logic [31:0]        wg;
      logic signed [63:0] prod;
      int                 row;
      o  = '0;
      wm = r.main_weight;
      wg = r.giant_weight;
      if (r.mode == wch_pkg::MODE_READ) begin
         if (r.component < wch_pkg::ROWS) begin
            o.bin_count        = hist_store[r.component * wch_pkg::MAX_BINS + r.read_bin];
            o.row_weight_total = weight_acc[r.component];
            o.row_colour_sum   = colour_acc[r.component];
            o.row_giant_total  = giant_acc[r.component];
         end
         return o;
      end
      o.in_window = (r.apparent_mag >= bright_lim) && (r.apparent_mag <= faint_lim);
      o.main_bin  = colour_bin(r.main_colour);
      o.giant_bin = colour_bin(r.giant_colour);
      if (!o.in_window) begin
         wm = '0;
         wg = '0;
      end
      if (r.component < wch_pkg::COMPONENTS) begin
         prod = longint'(wm) * longint'(r.main_colour)
              + longint'(wg) * longint'(r.giant_colour);
         // own row first, then the totals row
         for (int k = 0; k < 2; k++) begin
            row = (k == 0) ? r.component : wch_pkg::COMPONENTS;
            hist_store[row * wch_pkg::MAX_BINS + o.main_bin] =
               sat_add48(hist_store[row * wch_pkg::MAX_BINS + o.main_bin], wm);
            hist_store[row * wch_pkg::MAX_BINS + o.giant_bin] =
               sat_add48(hist_store[row * wch_pkg::MAX_BINS + o.giant_bin], wg);
            colour_acc[row] = sat_add64(colour_acc[row], prod);
            weight_acc[row] = sat_add48(weight_acc[row], {1'b0, wm} + {1'b0, wg});
            giant_acc[row]  = sat_add48(giant_acc[row], wg);
         end
         o.row_weight_total = weight_acc[r.component];
         o.row_colour_sum   = colour_acc[r.component];
         o.row_giant_total  = giant_acc[r.component];
      end
      return o;
   endfunction

   // ------------------------------------------------------------- checking
   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h at %0t", name, want, got, $realtime);
      end
   endtask

   always @(posedge clock) begin : result_monitor
      wch_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transaction at %0t", $realtime);
         end else begin
            want = pending_rsp.pop_front();
            check_field("in_window",        want.in_window,        rsp_data.in_window);
            check_field("main_bin",         want.main_bin,         rsp_data.main_bin);
            check_field("giant_bin",        want.giant_bin,        rsp_data.giant_bin);
            check_field("bin_count",        want.bin_count,        rsp_data.bin_count);
            check_field("row_weight_total", want.row_weight_total,
                        rsp_data.row_weight_total);
            check_field("row_colour_sum",   want.row_colour_sum,   rsp_data.row_colour_sum);
            check_field("row_giant_total",  want.row_giant_total,  rsp_data.row_giant_total);
         end
      end
   end

   // -------------------------------------------------------------- driving
   // one transaction: random gap while idling is on, then hold start until busy is seen low
   task automatic send_item(wch_pkg::req_type r, bit typed, wch_pkg::rsp_type e);
      wch_pkg::rsp_type p;
      while (idle_on && $urandom_range(0, 99) < 23) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      p = histogram_step(r);
      pending_rsp.push_back(typed ? e : p);
   endtask

   // csr writes only once the block has drained
   task automatic csr_write(wch_pkg::csr_index_type idx, logic [15:0] value);
      start <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (40) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         wch_pkg::CSR_BRIGHT_LIMIT: bright_lim = value;
         wch_pkg::CSR_FAINT_LIMIT:  faint_lim  = value;
         wch_pkg::CSR_BIN_WIDTH:    bin_wid    = value[14:0];
         wch_pkg::CSR_LAST_BIN:     top_bin    = value[5:0];
         default: ;
      endcase
   endtask

   function automatic wch_pkg::req_type mk(wch_pkg::mode_type m, logic [2:0] c,
                                           logic [15:0] mag,
                                           logic [31:0] wm, logic [31:0] wg,
                                           logic [15:0] cm, logic [15:0] cg,
                                           logic [5:0] rb);
      wch_pkg::req_type r;
      r = '{m, c, mag, wm, wg, cm, cg, rb};
      return r;
   endfunction

   task automatic add_row(wch_pkg::req_type r, bit typed, wch_pkg::rsp_type e);
      row_type x;
      x.r     = r;
      x.typed = typed;
      x.e     = e;
      directed.push_back(x);
   endtask

   function automatic logic [15:0] pick_mag();
      case ($urandom_range(0, 3))
         0:       return bright_lim + 16'($urandom_range(0, 4)) - 16'd2;
         1:       return faint_lim + 16'($urandom_range(0, 4)) - 16'd2;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_weight();
      case ($urandom_range(0, 5))
         0:       return 32'hFFFF_FFFF;
         1:       return '0;
         2:       return 32'($urandom_range(0, 1 << 17));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_colour();
      int unsigned w;
      w = (bin_wid == 0) ? 1 : bin_wid;
      case ($urandom_range(0, 4))
         0:       return 16'(w * $urandom_range(0, 70)) + 16'($urandom_range(0, 2)) - 16'd1;
         1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic wch_pkg::req_type random_item();
      wch_pkg::req_type r;
      r.mode         = ($urandom_range(0, 3) == 0) ? wch_pkg::MODE_READ
                                                   : wch_pkg::MODE_ACCUMULATE;
      // mostly real rows and the totals row, now and then the rows beyond
      r.component    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
      r.apparent_mag = pick_mag();
      r.main_weight  = pick_weight();
      r.giant_weight = pick_weight();
      r.main_colour  = pick_colour();
      r.giant_colour = pick_colour();
      r.read_bin     = 6'($urandom);
      return r;
   endfunction

   // ------------------------------------------------------------- stimulus
   initial begin
      wch_pkg::rsp_type z;
      wch_pkg::rsp_type e;
      clock      = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_addr   = wch_pkg::CSR_BRIGHT_LIMIT;
      csr_wdata  = '0;
      mismatches = 0;
      idle_on    = 1'b1;
      bright_lim = -16'sd32768;
      faint_lim  = 16'sd32767;
      bin_wid    = 15'd1024;
      top_bin    = 6'd63;
      foreach (hist_store[i]) hist_store[i] = '0;
      foreach (colour_acc[i]) begin
         colour_acc[i] = '0;
         weight_acc[i] = '0;
         giant_acc[i]  = '0;
      end
      z = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // memory clear pass keeps busy high for a while
      do @(posedge clock); while (busy);

      // reads after reset see empty stores
      add_row(mk(wch_pkg::MODE_READ, 3'd0, 16'h0, '0, '0, '0, '0, 6'd0), 1, z);
      add_row(mk(wch_pkg::MODE_READ, 3'd4, 16'h0, '0, '0, '0, '0, 6'd63), 1, z);
      add_row(mk(wch_pkg::MODE_READ, 3'd7, 16'h0, '0, '0, '0, '0, 6'd63), 1, z);
      // accumulate into the totals row or beyond changes nothing, sums read as zero
      e = '0;
      e.in_window = 1'b1;
      e.main_bin  = 6'd31;
      add_row(mk(wch_pkg::MODE_ACCUMULATE, 3'd4, 16'h0, '1, '1, 16'h7FFF, 16'h8000, 6'd0),
              1, e);
      e.main_bin  = 6'd0;
      e.giant_bin = 6'd1;
      add_row(mk(wch_pkg::MODE_ACCUMULATE, 3'd7, 16'h8000, '1, '1, 16'h0, 16'd1024, 6'd0),
              1, e);
      // extremes of weights, colours and magnitude
      add_row(mk(wch_pkg::MODE_ACCUMULATE, 3'd0, 16'h8000, '1, '1, 16'h7FFF, 16'h8000,
                 6'd0), 0, z);
      add_row(mk(wch_pkg::MODE_ACCUMULATE, 3'd0, 16'h7FFF, '1, '1, 16'h8000, 16'h7FFF,
                 6'd0), 0, z);
      add_row(mk(wch_pkg::MODE_ACCUMULATE, 3'd3, 16'h0, '0, '1, 16'd1023, 16'd1024, 6'd0),
              0, z);
      add_row(mk(wch_pkg::MODE_ACCUMULATE, 3'd1, 16'h1, 32'h1, '0, 16'hFFFF, 16'd2047,
                 6'd0), 0, z);
      add_row(mk(wch_pkg::MODE_ACCUMULATE, 3'd2, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555,
                 16'h5555, 16'h2AAA, 6'd0), 0, z);
      add_row(mk(wch_pkg::MODE_ACCUMULATE, 3'd5, 16'h1234, '1, '1, 16'h7000, 16'h0400,
                 6'd0), 0, z);
      add_row(mk(wch_pkg::MODE_ACCUMULATE, 3'd6, 16'hFFFF, '1, '1, 16'h0800, 16'hF000,
                 6'd0), 0, z);
      // read back what the rows gathered
      add_row(mk(wch_pkg::MODE_READ, 3'd0, 16'h0, '0, '0, '0, '0, 6'd31), 0, z);
      add_row(mk(wch_pkg::MODE_READ, 3'd0, 16'h0, '0, '0, '0, '0, 6'd0), 0, z);
      add_row(mk(wch_pkg::MODE_READ, 3'd1, 16'hFFFF, '1, '1, '1, '1, 6'd1), 0, z);
      add_row(mk(wch_pkg::MODE_READ, 3'd2, 16'h0, '0, '0, '0, '0, 6'd21), 0, z);
      add_row(mk(wch_pkg::MODE_READ, 3'd3, 16'h0, '0, '0, '0, '0, 6'd1), 0, z);
      add_row(mk(wch_pkg::MODE_READ, 3'd4, 16'h0, '0, '0, '0, '0, 6'd31), 0, z);
      add_row(mk(wch_pkg::MODE_READ, 3'd4, 16'h0, '0, '0, '0, '0, 6'd0), 0, z);
      add_row(mk(wch_pkg::MODE_READ, 3'd5, 16'h0, '1, '1, '1, '1, 6'd0), 1, z);

      foreach (directed[i]) send_item(directed[i].r, directed[i].typed, directed[i].e);

      // random phases, each under its own csr setting
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin // reset values written back explicitly
               csr_write(wch_pkg::CSR_BRIGHT_LIMIT, 16'h8000);
               csr_write(wch_pkg::CSR_FAINT_LIMIT,  16'h7FFF);
               csr_write(wch_pkg::CSR_BIN_WIDTH,    16'd1024);
               csr_write(wch_pkg::CSR_LAST_BIN,     16'd63);
            end
            1: begin // empty window, zero bin width, single bin
               csr_write(wch_pkg::CSR_BRIGHT_LIMIT, 16'h7FFF);
               csr_write(wch_pkg::CSR_FAINT_LIMIT,  16'h8000);
               csr_write(wch_pkg::CSR_BIN_WIDTH,    16'd0);
               csr_write(wch_pkg::CSR_LAST_BIN,     16'd0);
            end
            2: begin // one-value window at the bright end, widest bins
               csr_write(wch_pkg::CSR_BRIGHT_LIMIT, 16'h8000);
               csr_write(wch_pkg::CSR_FAINT_LIMIT,  16'h8000);
               csr_write(wch_pkg::CSR_BIN_WIDTH,    16'h7FFF);
               csr_write(wch_pkg::CSR_LAST_BIN,     16'd63);
            end
            3: begin // narrow bins so the clamp is hit often
               csr_write(wch_pkg::CSR_BRIGHT_LIMIT, 16'hFC00);
               csr_write(wch_pkg::CSR_FAINT_LIMIT,  16'h0400);
               csr_write(wch_pkg::CSR_BIN_WIDTH,    16'd1);
               csr_write(wch_pkg::CSR_LAST_BIN,     16'd40);
            end
            default: begin
               csr_write(wch_pkg::CSR_BRIGHT_LIMIT,
                         16'($urandom_range(0, 65535)) | 16'h8000);
               csr_write(wch_pkg::CSR_FAINT_LIMIT, 16'($urandom_range(0, 32767)));
               csr_write(wch_pkg::CSR_BIN_WIDTH,
                         ($urandom_range(0, 1) ? 16'($urandom_range(1, 4096))
                                               : 16'($urandom_range(0, 32767))));
               csr_write(wch_pkg::CSR_LAST_BIN, 16'($urandom_range(0, 63)));
            end
         endcase
         // one phase runs back to back with no idling at all
         idle_on = (ph != 4);
         for (int n = 0; n < 195; n++) send_item(random_item(), 0, z);
      end
      start <= 1'b0;

      wait (pending_rsp.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
